// ----- rtl/ookpct_pkg.sv -----
package ookpct_pkg;

  localparam int CFG_W   = 12;
  localparam int PULSE_W = 12;
  localparam int MULT_W  = 7;
  localparam int REP_W   = 8;
  localparam int PROTO_W = 3;

  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_PROTOCOL = 2'd0;
  localparam reg_idx_t REG_PULSE    = 2'd1;
  localparam reg_idx_t REG_REPEAT   = 2'd2;
  localparam reg_idx_t REG_ENABLE   = 2'd3;

  localparam logic [PROTO_W-1:0] PROTOCOL_RESET = 3'd1;
  localparam logic [PULSE_W-1:0] PULSE_RESET    = 12'd350;
  localparam logic [REP_W-1:0]   REPEAT_RESET   = 8'd10;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_DATA_A = 3'd1,
    PH_DATA_B = 3'd2,
    PH_SYNC_A = 3'd3,
    PH_SYNC_B = 3'd4
  } phase_t;

  typedef struct packed {
    logic [PULSE_W-1:0] base;
    logic [MULT_W-1:0]  sync_a;
    logic [MULT_W-1:0]  sync_b;
    logic [MULT_W-1:0]  zero_a;
    logic [MULT_W-1:0]  zero_b;
    logic [MULT_W-1:0]  one_a;
    logic [MULT_W-1:0]  one_b;
    logic               inverted;
  } proto_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic frame_done;
  } result_t;

  // out-of-range selections fall back to protocol 1
  function automatic proto_t proto_lookup(input logic [PROTO_W-1:0] sel);
    proto_t p;
    unique case (sel)
      3'd2:    p = '{12'd650, 7'd1,  7'd10, 7'd1, 7'd2,  7'd2, 7'd1, 1'b0};
      3'd3:    p = '{12'd100, 7'd30, 7'd71, 7'd4, 7'd11, 7'd9, 7'd6, 1'b0};
      3'd4:    p = '{12'd380, 7'd1,  7'd6,  7'd1, 7'd3,  7'd3, 7'd1, 1'b0};
      3'd5:    p = '{12'd500, 7'd6,  7'd14, 7'd1, 7'd2,  7'd2, 7'd1, 1'b0};
      3'd6:    p = '{12'd450, 7'd23, 7'd1,  7'd1, 7'd2,  7'd2, 7'd1, 1'b1};
      default: p = '{12'd350, 7'd1,  7'd31, 7'd1, 7'd3,  7'd3, 7'd1, 1'b0};
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/ookpct_in_if.sv -----
interface ookpct_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] code_bits;
  logic [5:0]  bit_count;

  modport source (output valid, kind, code_bits, bit_count, input ready);
  modport sink   (input valid, kind, code_bits, bit_count, output ready);
endinterface

// ----- rtl/ookpct_out_if.sv -----
interface ookpct_out_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic busy_res;
  logic frame_done;

  modport source (output valid, pin_level, busy_res, frame_done, input ready);
  modport sink   (input valid, pin_level, busy_res, frame_done, output ready);
endinterface

// ----- rtl/ook_pulse_code_transmitter_core.sv -----
// channel   dir  beat contents
// item      in   kind, code_bits, bit_count (tick or start)
// result    out  pin_level, busy_res, frame_done (one per item)
// wr_*      in   wr_en, wr_index, wr_data (config write, no handshake)
//
// one item per cycle while item.ready is high; its result is registered
// the state update for an item is one pass of logic between the accepted beat and
// the result register; an output register plus a one-entry skid slot hold results
// reset (rst, synchronous) loads the register defaults and idles the transmitter
// item.ready drops only when both the output register and the skid slot are full
module ook_pulse_code_transmitter_core #(
  parameter int CODE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  ookpct_in_if.sink                    item,
  ookpct_out_if.source                 result,
  input  logic                         wr_en,
  input  ookpct_pkg::reg_idx_t         wr_index,
  input  logic [ookpct_pkg::CFG_W-1:0] wr_data
);
  import ookpct_pkg::*;

  localparam int IDX_W = $clog2(CODE_WIDTH + 1);
  localparam int POS_W = $clog2(CODE_WIDTH);
  localparam logic [6:0] CODE_WIDTH7 = 7'(CODE_WIDTH);

  // configuration
  logic [PROTO_W-1:0] protocol_select;
  logic [PULSE_W-1:0] pulse_length;
  logic [REP_W-1:0]   repeat_count;
  logic               transmit_enable;

  // transmitter state
  logic [CODE_WIDTH-1:0] shift_code, shift_code_next;
  logic [IDX_W-1:0]      bit_index, bit_index_next;
  logic [IDX_W-1:0]      frame_length, frame_length_next;
  logic [REP_W-1:0]      repeats_left, repeats_left_next;
  phase_t                phase, phase_next;
  logic [PULSE_W-1:0]    unit_counter, unit_counter_next;
  logic [MULT_W-1:0]     multiple_counter, multiple_counter_next;
  logic                  active, active_next;
  logic                  line_level, line_level_next;
  logic                  done_next;

  // output register and skid slot
  logic    out_valid, skid_valid;
  result_t out_data, skid_data, res;

  logic in_fire, out_fire;
  assign item.ready = !skid_valid;
  assign in_fire    = item.valid && item.ready;
  assign out_fire   = out_valid && result.ready;

  proto_t             proto;
  logic [POS_W-1:0]   bit_pos;
  logic               cur_bit;
  logic [MULT_W-1:0]  mult;
  logic [MULT_W-1:0]  mc_inc;
  logic               unit_end;
  logic [6:0]         n7;
  logic [IDX_W-1:0]   n_bits;
  logic [IDX_W-1:0]   dec_index;
  logic [REP_W-1:0]   dec_repeats;

  assign proto     = proto_lookup(protocol_select);
  assign bit_pos   = POS_W'(bit_index - IDX_W'(1));
  assign cur_bit   = shift_code[bit_pos];
  assign mc_inc    = multiple_counter + MULT_W'(1);
  assign unit_end  = (13'(unit_counter) + 13'd1) >= 13'(pulse_length);
  assign n7        = ({1'b0, item.bit_count} > CODE_WIDTH7) ? CODE_WIDTH7
                                                             : {1'b0, item.bit_count};
  assign n_bits    = n7[IDX_W-1:0];
  assign dec_index = bit_index - IDX_W'(1);
  assign dec_repeats = repeats_left - REP_W'(1);

  always_comb begin
    unique case (phase)
      PH_DATA_A: mult = cur_bit ? proto.one_a : proto.zero_a;
      PH_DATA_B: mult = cur_bit ? proto.one_b : proto.zero_b;
      PH_SYNC_A: mult = proto.sync_a;
      PH_SYNC_B: mult = proto.sync_b;
      default:   mult = MULT_W'(1);
    endcase
  end

  // next state for one accepted beat
  always_comb begin
    shift_code_next       = shift_code;
    bit_index_next        = bit_index;
    frame_length_next     = frame_length;
    repeats_left_next     = repeats_left;
    phase_next            = phase;
    unit_counter_next     = unit_counter;
    multiple_counter_next = multiple_counter;
    active_next           = active;
    line_level_next       = line_level;
    done_next             = 1'b0;
    if (in_fire) begin
      if (item.kind == KIND_TICK) begin
        if (active) begin
          if (unit_end) begin
            unit_counter_next     = '0;
            multiple_counter_next = mc_inc;
            if (mc_inc >= mult) begin
              multiple_counter_next = '0;
              unique case (phase)
                PH_DATA_A: begin
                  phase_next      = PH_DATA_B;
                  line_level_next = !proto.inverted;
                end
                PH_SYNC_A: begin
                  phase_next      = PH_SYNC_B;
                  line_level_next = !proto.inverted;
                end
                PH_DATA_B: begin
                  bit_index_next  = dec_index;
                  phase_next      = (dec_index != '0) ? PH_DATA_A : PH_SYNC_A;
                  line_level_next = proto.inverted;
                end
                PH_SYNC_B: begin
                  repeats_left_next = dec_repeats;
                  if (dec_repeats == '0) begin
                    active_next = 1'b0;
                    phase_next  = PH_IDLE;
                    done_next   = 1'b1;
                  end else begin
                    bit_index_next  = frame_length;
                    phase_next      = (frame_length != '0) ? PH_DATA_A : PH_SYNC_A;
                    line_level_next = proto.inverted;
                  end
                end
                default: phase_next = PH_IDLE;
              endcase
            end
          end else begin
            unit_counter_next = unit_counter + PULSE_W'(1);
          end
        end
      end else if (transmit_enable && !active && repeat_count != '0) begin
        shift_code_next       = CODE_WIDTH'(item.code_bits);
        frame_length_next     = n_bits;
        bit_index_next        = n_bits;
        repeats_left_next     = repeat_count;
        active_next           = 1'b1;
        phase_next            = (n_bits != '0) ? PH_DATA_A : PH_SYNC_A;
        unit_counter_next     = '0;
        multiple_counter_next = '0;
        line_level_next       = proto.inverted;
      end
    end
  end

  // result fields for the beat
  always_comb begin
    res.pin_level  = line_level_next;
    res.busy_res   = active_next;
    res.frame_done = done_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_select <= PROTOCOL_RESET;
      pulse_length    <= PULSE_RESET;
      repeat_count    <= REPEAT_RESET;
      transmit_enable <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PROTOCOL: begin
          protocol_select <= wr_data[PROTO_W-1:0];
          pulse_length    <= proto_lookup(wr_data[PROTO_W-1:0]).base;
        end
        REG_PULSE:  pulse_length    <= wr_data[PULSE_W-1:0];
        REG_REPEAT: repeat_count    <= wr_data[REP_W-1:0];
        REG_ENABLE: transmit_enable <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_index        <= '0;
      frame_length     <= '0;
      repeats_left     <= '0;
      phase            <= PH_IDLE;
      unit_counter     <= '0;
      multiple_counter <= '0;
      active           <= 1'b0;
      line_level       <= 1'b0;
    end else begin
      bit_index        <= bit_index_next;
      frame_length     <= frame_length_next;
      repeats_left     <= repeats_left_next;
      phase            <= phase_next;
      unit_counter     <= unit_counter_next;
      multiple_counter <= multiple_counter_next;
      active           <= active_next;
      line_level       <= line_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_code <= '0;
    end else begin
      shift_code <= shift_code_next;
    end
  end

  // output register with skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_fire) begin
      out_valid  <= skid_valid || in_fire;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_fire) begin
      out_data <= skid_valid ? skid_data : res;
    end else if (in_fire) begin
      skid_data <= res;
    end
  end

  assign result.valid      = out_valid;
  assign result.pin_level  = out_data.pin_level;
  assign result.busy_res   = out_data.busy_res;
  assign result.frame_done = out_data.frame_done;

`ifndef ASSERT_OFF
  a_active_phase: assert property (@(posedge clk) disable iff (rst)
    active == (phase != PH_IDLE))
    else $error("active flag and phase disagree");

  a_data_has_bits: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA_A || phase == PH_DATA_B) |-> bit_index != '0)
    else $error("data phase with no bits left");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot full while output register empty");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.frame_done) |-> !result.busy_res)
    else $error("frame done reported while still busy");
`endif

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import ookpct_pkg::*;

  localparam int CODE_BITS = 32;

  typedef struct packed {
    logic        kind;
    logic [31:0] code;
    logic [5:0]  count;
  } item_beat_t;

  typedef struct {
    int base;
    int sync_a;
    int sync_b;
    int zero_a;
    int zero_b;
    int one_a;
    int one_b;
    bit inverted;
  } shape_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             wr_en;
  reg_idx_t         wr_index;
  logic [CFG_W-1:0] wr_data;

  ookpct_in_if  in_ch ();
  ookpct_out_if res_ch ();

  ook_pulse_code_transmitter_core #(
    .CODE_WIDTH(CODE_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .item     (in_ch),
    .result   (res_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #5 clk = ~clk;

  // register copies
  logic [PROTO_W-1:0] cfg_proto;
  logic [PULSE_W-1:0] cfg_pulse;
  logic [REP_W-1:0]   cfg_repeat;
  logic               cfg_enable;

  // transmitter state
  logic [31:0]       tx_code;
  logic [5:0]        bits_left;
  logic [5:0]        frame_bits;
  logic [REP_W-1:0]  reps_left;
  phase_t            tx_phase;
  logic [PULSE_W-1:0] unit_cnt;
  logic [MULT_W-1:0] mult_cnt;
  logic              tx_active;
  logic              line;

  item_beat_t tx_items_q[$];
  result_t    due_levels_q[$];

  int  items_taken = 0;
  int  results_seen = 0;
  int  send_wait = 0;
  int  rcv_wait = 0;
  bit  in_taken = 1'b0;
  bit  calm = 1'b0;
  bit  failed = 1'b0;

  function automatic shape_t shape_of(input logic [PROTO_W-1:0] sel);
    shape_t s;
    case (sel)
      3'd2:    s = '{650, 1, 10, 1, 2, 2, 1, 1'b0};
      3'd3:    s = '{100, 30, 71, 4, 11, 9, 6, 1'b0};
      3'd4:    s = '{380, 1, 6, 1, 3, 3, 1, 1'b0};
      3'd5:    s = '{500, 6, 14, 1, 2, 2, 1, 1'b0};
      3'd6:    s = '{450, 23, 1, 1, 2, 2, 1, 1'b1};
      default: s = '{350, 1, 31, 1, 3, 3, 1, 1'b0};
    endcase
    return s;
  endfunction

  function automatic int phase_mult();
    shape_t s;
    logic   b;
    s = shape_of(cfg_proto);
    b = (bits_left != 0) ? tx_code[bits_left - 1] : 1'b0;
    case (tx_phase)
      PH_DATA_A: return b ? s.one_a : s.zero_a;
      PH_DATA_B: return b ? s.one_b : s.zero_b;
      PH_SYNC_A: return s.sync_a;
      PH_SYNC_B: return s.sync_b;
      default:   return 1;
    endcase
  endfunction

  function automatic void enter_phase(input phase_t ph);
    shape_t s;
    s = shape_of(cfg_proto);
    tx_phase = ph;
    unit_cnt = '0;
    mult_cnt = '0;
    line = (ph == PH_DATA_A || ph == PH_SYNC_A) ? s.inverted : ~s.inverted;
  endfunction

  function automatic void begin_symbol();
    if (bits_left != 0) begin
      enter_phase(PH_DATA_A);
    end else begin
      enter_phase(PH_SYNC_A);
    end
  endfunction

  function automatic result_t step_transmitter(input item_beat_t b);
    result_t r;
    logic    done;
    done = 1'b0;
    if (b.kind == KIND_TICK) begin
      if (tx_active) begin
        if (int'(unit_cnt) + 1 >= int'(cfg_pulse)) begin
          unit_cnt = '0;
          mult_cnt = mult_cnt + 1'b1;
          if (int'(mult_cnt) >= phase_mult()) begin
            case (tx_phase)
              PH_DATA_A: enter_phase(PH_DATA_B);
              PH_SYNC_A: enter_phase(PH_SYNC_B);
              PH_DATA_B: begin
                bits_left = bits_left - 1'b1;
                begin_symbol();
              end
              default: begin
                reps_left = reps_left - 1'b1;
                if (reps_left == 0) begin
                  tx_active = 1'b0;
                  tx_phase = PH_IDLE;
                  unit_cnt = '0;
                  mult_cnt = '0;
                  done = 1'b1;
                end else begin
                  bits_left = frame_bits;
                  begin_symbol();
                end
              end
            endcase
          end
        end else begin
          unit_cnt = unit_cnt + 1'b1;
        end
      end
    end else if (cfg_enable && !tx_active && cfg_repeat != 0) begin
      // oversize counts clamp to the code width
      frame_bits = (b.count > CODE_BITS) ? 6'(CODE_BITS) : b.count;
      bits_left = frame_bits;
      tx_code = b.code;
      reps_left = cfg_repeat;
      tx_active = 1'b1;
      begin_symbol();
    end
    r.pin_level = line;
    r.busy_res = tx_active;
    r.frame_done = done;
    return r;
  endfunction

  function automatic int idle_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // sender
  always @(negedge clk) begin : drive_items
    item_beat_t beat;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (send_wait > 0) begin
        send_wait <= send_wait - 1;
        in_ch.valid <= 1'b0;
      end else if (tx_items_q.size() > 0) begin
        beat = tx_items_q.pop_front();
        in_ch.kind <= beat.kind;
        in_ch.code_bits <= beat.code;
        in_ch.bit_count <= beat.count;
        in_ch.valid <= 1'b1;
        send_wait <= idle_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (rcv_wait > 0) begin
      res_ch.ready <= 1'b0;
      rcv_wait <= rcv_wait - 1;
    end else begin
      res_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) rcv_wait <= idle_gap();
    end
  end

  always @(posedge clk) begin : observe
    item_beat_t beat;
    result_t    want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (res_ch.valid && res_ch.ready) begin
        results_seen <= results_seen + 1;
        if (due_levels_q.size() == 0) begin
          $error("result beat with nothing expected");
          failed = 1'b1;
        end else begin
          want = due_levels_q.pop_front();
          if (res_ch.pin_level !== want.pin_level) begin
            $error("pin_level expected %0b got %0b", want.pin_level, res_ch.pin_level);
            failed = 1'b1;
          end
          if (res_ch.busy_res !== want.busy_res) begin
            $error("busy_res expected %0b got %0b", want.busy_res, res_ch.busy_res);
            failed = 1'b1;
          end
          if (res_ch.frame_done !== want.frame_done) begin
            $error("frame_done expected %0b got %0b", want.frame_done, res_ch.frame_done);
            failed = 1'b1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        beat.kind = in_ch.kind;
        beat.code = in_ch.code_bits;
        beat.count = in_ch.bit_count;
        due_levels_q.push_back(step_transmitter(beat));
        items_taken <= items_taken + 1;
      end
    end
  end

  task automatic send(input logic k, input logic [31:0] c, input logic [5:0] n);
    item_beat_t beat;
    beat.kind = k;
    beat.code = c;
    beat.count = n;
    tx_items_q.push_back(beat);
  endtask

  task automatic wait_settled();
    do @(posedge clk);
    while (tx_items_q.size() != 0 || in_ch.valid || items_taken != results_seen);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int val);
    shape_t s;
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= CFG_W'(val);
    case (idx)
      REG_PROTOCOL: begin
        cfg_proto = PROTO_W'(val);
        s = shape_of(cfg_proto);
        cfg_pulse = PULSE_W'(s.base);
      end
      REG_PULSE:  cfg_pulse = PULSE_W'(val);
      REG_REPEAT: cfg_repeat = REP_W'(val);
      REG_ENABLE: cfg_enable = val[0];
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick_pulse();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 75) return 1;
    if (r < 90) return $urandom_range(2, 4);
    if (r < 97) return $urandom_range(5, 40);
    return $urandom_range(41, 4095);
  endfunction

  function automatic logic [5:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 6'($urandom_range(33, 63));
    if (r < 40) return 6'($urandom_range(9, 32));
    return 6'($urandom_range(0, 8));
  endfunction

  task automatic retune_live();
    if ($urandom_range(0, 2) == 0) write_reg(REG_PROTOCOL, $urandom_range(0, 7));
    write_reg(REG_PULSE, $urandom_range(0, 3));
    end_writes();
  endtask

  // tick in bursts until the transmitter goes idle or max_chunks bursts have run
  task automatic run_until_idle(input int max_chunks, input bit retune);
    int n;
    wait_settled();
    for (n = 0; n < max_chunks && tx_active; n++) begin
      if (retune && $urandom_range(0, 6) == 0) retune_live();
      repeat (24) begin
        if ($urandom_range(0, 99) < 3) begin
          send(KIND_START, $urandom, pick_count());
        end else begin
          send(KIND_TICK, $urandom, 6'($urandom_range(0, 63)));
        end
      end
      wait_settled();
    end
  endtask

  task automatic random_phase();
    calm = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1) == 0) write_reg(REG_PROTOCOL, $urandom_range(0, 7));
    write_reg(REG_PULSE, pick_pulse());
    if ($urandom_range(0, 9) < 6) begin
      write_reg(REG_REPEAT, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3));
    end
    if ($urandom_range(0, 4) == 0) write_reg(REG_ENABLE, ($urandom_range(0, 99) < 85));
    end_writes();
    repeat ($urandom_range(0, 3)) begin
      send(1'($urandom_range(0, 1)), $urandom, 6'($urandom_range(0, 63)));
    end
    send(KIND_START, $urandom, pick_count());
    run_until_idle(8, 1'b1);
  endtask

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = REG_PROTOCOL;
    wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_TICK;
    in_ch.code_bits = '0;
    in_ch.bit_count = '0;
    res_ch.ready = 1'b0;
    cfg_proto = PROTOCOL_RESET;
    cfg_pulse = PULSE_RESET;
    cfg_repeat = REPEAT_RESET;
    cfg_enable = 1'b0;
    tx_code = '0;
    bits_left = '0;
    frame_bits = '0;
    reps_left = '0;
    tx_phase = PH_IDLE;
    unit_cnt = '0;
    mult_cnt = '0;
    tx_active = 1'b0;
    line = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle tick and a start while disabled
    send(KIND_TICK, 32'h0, 6'd0);
    send(KIND_START, 32'hFFFF_FFFF, 6'd32);
    wait_settled();

    // zero repeat count sends nothing
    write_reg(REG_ENABLE, 1);
    write_reg(REG_REPEAT, 0);
    end_writes();
    send(KIND_START, 32'h0000_1234, 6'd8);
    send(KIND_TICK, 32'h0, 6'd0);
    wait_settled();

    // inverted protocol, zero pulse length, start while busy
    write_reg(REG_PROTOCOL, 6);
    write_reg(REG_PULSE, 0);
    write_reg(REG_REPEAT, 1);
    end_writes();
    send(KIND_START, 32'h0000_0005, 6'd3);
    send(KIND_TICK, 32'h0, 6'd0);
    send(KIND_START, 32'h0000_0000, 6'd0);
    run_until_idle(4, 1'b0);
    send(KIND_TICK, 32'h0, 6'd0);
    send(KIND_TICK, 32'h0, 6'd0);
    wait_settled();

    // out-of-range protocol and oversize bit count
    write_reg(REG_PROTOCOL, 7);
    write_reg(REG_PULSE, 1);
    write_reg(REG_REPEAT, 2);
    end_writes();
    send(KIND_START, 32'hA5C3_0F96, 6'd63);
    run_until_idle(20, 1'b0);

    // long pulse cut short mid-phase
    write_reg(REG_PROTOCOL, 3);
    write_reg(REG_PULSE, 4095);
    write_reg(REG_REPEAT, 1);
    end_writes();
    send(KIND_START, 32'h0, 6'd0);
    repeat (12) send(KIND_TICK, 32'h0, 6'd0);
    wait_settled();
    write_reg(REG_PULSE, 1);
    end_writes();
    run_until_idle(10, 1'b0);

    // repeat and enable changed mid-frame
    write_reg(REG_PROTOCOL, 2);
    write_reg(REG_PULSE, 2);
    end_writes();
    send(KIND_START, 32'h0000_0001, 6'd1);
    repeat (6) send(KIND_TICK, 32'h0, 6'd0);
    wait_settled();
    write_reg(REG_REPEAT, 5);
    write_reg(REG_ENABLE, 0);
    end_writes();
    send(KIND_START, 32'h0, 6'd4);
    run_until_idle(10, 1'b0);
    send(KIND_START, 32'hFFFF_0000, 6'd16);
    wait_settled();
    write_reg(REG_ENABLE, 1);
    end_writes();

    while (items_taken < 1600) random_phase();

    // long repeat run, left running at the end
    calm = 1'b0;
    write_reg(REG_PROTOCOL, 1);
    write_reg(REG_PULSE, 1);
    write_reg(REG_REPEAT, 255);
    write_reg(REG_ENABLE, 1);
    end_writes();
    send(KIND_START, 32'h0, 6'd0);
    run_until_idle(8, 1'b0);

    wait_settled();
    repeat (20) @(posedge clk);
    if (!failed && due_levels_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
